>>> rtl/core/wosc_pkg.sv
// ----------------------------------------------------------------------------
// wosc_pkg: shared types, constants and table math for the oscillator
// Register indexes, waveform codes, widths, and the integer sine builder
// that fills the quarter-wave table at elaboration.
// ----------------------------------------------------------------------------
package wosc_pkg;

  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned WAVE_W     = 2;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = 15;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WAVEFORM   = 2'd0,
    REG_AMPLITUDE  = 2'd1,
    REG_PHASE_STEP = 2'd2
  } reg_idx_t;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAWTOOTH = 2'd2
  } wave_t;

  // Settings the shaper needs; waveform kept raw so the unused code survives.
  typedef struct packed {
    logic [WAVE_W-1:0] waveform;
    logic [AMP_W-1:0]  amplitude;
  } cfg_t;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] LOW32  = 64'h00000000FFFFFFFF;

  // (a*b) >> 60 for a, b below 2^62, built from 32-bit partial products
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] a0, a1, b0, b1;
    logic [63:0] p00, p01, p10, p11;
    logic [63:0] mid, lo, hi;
    a0  = a & LOW32;
    a1  = a >> 32;
    b0  = b & LOW32;
    b1  = b >> 32;
    p00 = a0 * b0;
    p01 = a0 * b1;
    p10 = a1 * b0;
    p11 = a1 * b1;
    mid = (p00 >> 32) + (p01 & LOW32) + (p10 & LOW32);
    lo  = (p00 & LOW32) | (mid << 32);
    hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
    return (hi << 4) | (lo >> 60);
  endfunction

  // n over d by shift and subtract; table build only, d is small and nonzero
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32767*sin(x)), x in Q60, 0 <= x <= pi/2, Taylor series
  function automatic logic [MAG_W-1:0] sine_q(input logic [63:0] x);
    logic [63:0] x2, term, sum, k, rnd;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (k = 64'd1; k < 64'd40 && term != 64'd0; k++) begin
      term = div_u64(mul_q60(term, x2), (64'd2 * k) * (64'd2 * k + 64'd1));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rnd = (64'd32767 * (sum >> 20) + (64'd1 << 39)) >> 40;
    return rnd[MAG_W-1:0];
  endfunction

  // Quarter-wave entry j of a table with 2^tab_bits points per cycle
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned j,
                                                 input int unsigned tab_bits);
    logic [63:0] unit, qtr;
    logic [MAG_W-1:0] v;
    unit = (PI_Q60 >> 1) >> (tab_bits - 2);
    qtr  = 64'd1 << (tab_bits - 2);
    if (j == 0) begin
      v = '0;
    end else if (64'(j) == qtr) begin
      v = 15'd32767;
    end else begin
      v = sine_q(unit * 64'(j));
    end
    return v;
  endfunction

endpackage

>>> rtl/core/wosc_phase_acc.sv
// ----------------------------------------------------------------------------
// wosc_phase_acc: phase accumulator and input stage
// Takes the restart flag of each input beat, latches the phase used for that
// sample and advances the accumulator by the configured step.
// ----------------------------------------------------------------------------
module wosc_phase_acc #(
  parameter int unsigned PHASE_BITS = wosc_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [wosc_pkg::STEP_W-1:0] step,
  input  logic                        accept,
  input  logic                        restart,
  input  logic                        advance,
  output logic                        s1_valid,
  output logic [PHASE_BITS-1:0]       s1_phase
);
  import wosc_pkg::*;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] p_use;
  logic [PHASE_BITS-1:0] s1_phase_r;
  logic                  s1_valid_r, s1_valid_nxt;

  assign p_use     = restart ? '0 : phase_r;
  // step is zero-extended or truncated to the accumulator width; sum wraps
  assign phase_nxt = p_use + PHASE_BITS'(step);

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_phase_r <= p_use;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_phase = s1_phase_r;

endmodule

>>> rtl/core/wosc_sine_lut.sv
// ----------------------------------------------------------------------------
// wosc_sine_lut: full-wave sine from a quarter-wave constant table
// Folds the index by quadrant, reads the magnitude and returns the sign.
// ----------------------------------------------------------------------------
module wosc_sine_lut #(
  parameter int unsigned SINE_TABLE_BITS = wosc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic [SINE_TABLE_BITS-1:0]  idx,
  output logic [wosc_pkg::MAG_W-1:0]  mag,
  output logic                        neg
);
  import wosc_pkg::*;

  localparam int unsigned QTR_SIZE = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned ADDR_W   = SINE_TABLE_BITS - 1;
  localparam logic [ADDR_W-1:0] QTR_ADDR = ADDR_W'(QTR_SIZE);

  logic [MAG_W-1:0]          qtab [QTR_SIZE+1];
  logic [1:0]                quad;
  logic [SINE_TABLE_BITS-3:0] rem;
  logic [ADDR_W-1:0]         addr;

  for (genvar j = 0; j <= QTR_SIZE; j++) begin : g_tab
    localparam logic [MAG_W-1:0] ENTRY = sine_entry(j, SINE_TABLE_BITS);
    assign qtab[j] = ENTRY;
  end

  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign rem  = idx[SINE_TABLE_BITS-3:0];
  // odd quadrants run the quarter backwards
  assign addr = quad[0] ? (QTR_ADDR - ADDR_W'(rem)) : ADDR_W'(rem);
  assign mag  = qtab[addr];
  assign neg  = quad[1];

endmodule

>>> rtl/core/wosc_shaper.sv
// ----------------------------------------------------------------------------
// wosc_shaper: waveform shaping and output register
// Turns the latched phase into a sample for the selected waveform and holds
// it in the output register until the receiver takes the beat.
// ----------------------------------------------------------------------------
module wosc_shaper #(
  parameter int unsigned PHASE_BITS      = wosc_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = wosc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wosc_pkg::cfg_t                      cfg,
  input  logic                                s1_valid,
  input  logic [PHASE_BITS-1:0]               s1_phase,
  input  logic                                out_stall,
  output logic                                advance,
  output logic                                out_valid,
  output logic signed [wosc_pkg::SAMPLE_W-1:0] out_sample
);
  import wosc_pkg::*;

  localparam int unsigned SAW_W = AMP_W + PHASE_BITS;

  logic [MAG_W-1:0]           sin_mag;
  logic                       sin_neg;
  logic [MAG_W+AMP_W-1:0]     sin_prod;
  logic [SAMPLE_W-1:0]        sin_pos;
  logic [SAW_W-1:0]           saw_prod;
  logic [SAMPLE_W-1:0]        amp_ext;
  logic                       sq_high;
  logic [SAMPLE_W-1:0]        sample_nxt;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_sample_r;

  wosc_sine_lut #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_lut (
    .idx(s1_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
    .mag(sin_mag),
    .neg(sin_neg)
  );

  assign sin_prod = sin_mag * cfg.amplitude;
  assign sin_pos  = SAMPLE_W'(sin_prod[MAG_W+AMP_W-1:AMP_W]);
  assign saw_prod = SAW_W'(cfg.amplitude) * SAW_W'(s1_phase);
  assign amp_ext  = SAMPLE_W'(cfg.amplitude);
  // strictly inside the first half cycle; zero and one half go low
  assign sq_high  = (s1_phase != '0) && !s1_phase[PHASE_BITS-1];

  always_comb begin
    unique case (cfg.waveform)
      WAVE_SINE:     sample_nxt = sin_neg ? (SAMPLE_W'(0) - sin_pos) : sin_pos;
      WAVE_SQUARE:   sample_nxt = sq_high ? amp_ext : (SAMPLE_W'(0) - amp_ext);
      WAVE_SAWTOOTH: sample_nxt = SAMPLE_W'(saw_prod[SAW_W-1 -: AMP_W]);
      default:       sample_nxt = '0;
    endcase
  end

  assign advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

>>> rtl/core/waveform_oscillator.sv
// ----------------------------------------------------------------------------
// waveform_oscillator: phase-accumulator audio oscillator
// Each input beat (restart flag) yields one signed 16-bit sample of a sine,
// square or sawtooth wave, then advances the phase by the configured step.
//
// Channels: in_valid/in_stall/in_restart in, out_valid/out_stall/out_sample
// out; a beat moves when valid is high and stall is low. Settings come in
// over cfg_we/cfg_index/cfg_data (0 waveform, 1 amplitude, 2 phase step); the
// user must write them only while no beat is in flight; the block has no guard.
// A taken beat is registered in the input stage, then in the output register.
// Throughput: one beat per cycle without out_stall; the path per stage is one
// sine table read plus one 15x15 multiply, or one amplitude-by-phase multiply.
// Reset: phase, settings and both pipeline valids clear; no sample pending.
// Stall: a stalled sample holds in the output register; the input stage
// still takes one more beat, then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module waveform_oscillator #(
  parameter int unsigned PHASE_BITS      = wosc_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = wosc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wosc_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                 cfg_we,
  input  logic [wosc_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [wosc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wosc_pkg::*;

  logic [WAVE_W-1:0]     waveform_r;
  logic [AMP_W-1:0]      amplitude_r;
  logic [STEP_W-1:0]     phase_step_r;
  cfg_t                  cfg;
  logic                  in_beat;
  logic                  advance;
  logic                  s1_valid;
  logic [PHASE_BITS-1:0] s1_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r   <= '0;
      amplitude_r  <= '0;
      phase_step_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WAVEFORM:   waveform_r   <= cfg_data[WAVE_W-1:0];
        REG_AMPLITUDE:  amplitude_r  <= cfg_data[AMP_W-1:0];
        REG_PHASE_STEP: phase_step_r <= cfg_data[STEP_W-1:0];
        default:        ;
      endcase
    end
  end

  assign cfg.waveform  = waveform_r;
  assign cfg.amplitude = amplitude_r;

  assign in_stall = s1_valid && !advance;
  assign in_beat  = in_valid && !in_stall;

  wosc_phase_acc #(
    .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (phase_step_r),
    .accept  (in_beat),
    .restart (in_restart),
    .advance (advance),
    .s1_valid(s1_valid),
    .s1_phase(s1_phase)
  );

  wosc_shaper #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_shaper (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_phase  (s1_phase),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .out_sample(out_sample)
  );

  a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> s1_valid)
    else $error("accepted beat did not reach the input stage");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid && $stable(s1_phase))
    else $error("input stage lost its beat while blocked");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_restart |=> s1_phase == '0)
    else $error("restart beat did not start from phase zero");

endmodule

>>> bench/wosc_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wosc_sample_checker: sample predictor and scoreboard for the oscillator
// Tracks register writes and accepted input beats, works out each sample
// from its own phase accumulator and sine table, and compares every
// accepted output beat in order. Reports a failure count and the number
// of samples still owed to the top.
// ----------------------------------------------------------------------------
module wosc_sample_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 in_restart,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [wosc_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                 cfg_we,
  input  logic [wosc_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [wosc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   fail_count,
  output int                                   outstanding
);
  import wosc_pkg::*;

  localparam int PHASE_W  = PHASE_BITS_DEF;
  localparam int TAB_BITS = SINE_TABLE_BITS_DEF;
  localparam int QTR      = 1 << (TAB_BITS - 2);
  localparam int SHOWN    = 10;

  logic [MAG_W-1:0]          quarter_wave [0:QTR];
  logic [WAVE_W-1:0]         wave_sel;
  logic [AMP_W-1:0]          amp;
  logic [STEP_W-1:0]         phase_inc;
  logic [PHASE_W-1:0]        phase;
  logic signed [SAMPLE_W-1:0] owed_q [$];
  logic signed [SAMPLE_W-1:0] want;
  int                        fails;

  // round(32767*sin) over the first quarter; the ends are exact
  initial begin
    real v;
    for (int j = 0; j <= QTR; j++) begin
      v = 32767.0 * $sin(3.14159265358979323846 * j / (2.0 * QTR));
      quarter_wave[j] = (j == 0) ? '0 : (j == QTR) ? 15'd32767 : MAG_W'($rtoi(v + 0.5));
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] synth_sample(input logic restart);
    logic [TAB_BITS-1:0]        idx;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W+AMP_W-1:0]     prod;
    logic [AMP_W+PHASE_W-1:0]   ramp;
    logic signed [SAMPLE_W-1:0] s;
    if (restart) phase = '0;
    idx = phase[PHASE_W-1 -: TAB_BITS];
    s   = '0;
    case (wave_sel)
      WAVE_SINE: begin
        // odd quadrants run the quarter table backwards, upper half negates
        mag  = idx[TAB_BITS-2] ? quarter_wave[QTR - int'(idx[TAB_BITS-3:0])]
                               : quarter_wave[idx[TAB_BITS-3:0]];
        prod = mag * amp;
        s    = $signed({1'b0, prod[MAG_W+AMP_W-1:15]});
        if (idx[TAB_BITS-1]) s = -s;
      end
      WAVE_SQUARE: begin
        s = (phase != '0 && !phase[PHASE_W-1]) ? $signed({1'b0, amp})
                                               : -$signed({1'b0, amp});
      end
      WAVE_SAWTOOTH: begin
        ramp = (AMP_W+PHASE_W)'(amp) * (AMP_W+PHASE_W)'(phase);
        s    = $signed({1'b0, ramp[AMP_W+PHASE_W-1:PHASE_W]});
      end
      default: s = '0;
    endcase
    phase = phase + PHASE_W'(phase_inc);
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wave_sel  = '0;
      amp       = '0;
      phase_inc = '0;
      phase     = '0;
      fails     = 0;
      owed_q.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WAVEFORM:   wave_sel  = cfg_data[WAVE_W-1:0];
          REG_AMPLITUDE:  amp       = cfg_data[AMP_W-1:0];
          REG_PHASE_STEP: phase_inc = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      // output side first so a beat can never match its own input
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          fails++;
          if (fails <= SHOWN)
            $display("%0t: sample %0d with nothing expected", $time, out_sample);
        end else begin
          want = owed_q.pop_front();
          if (out_sample !== want) begin
            fails++;
            if (fails <= SHOWN)
              $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, out_sample);
          end
        end
      end
      if (in_valid && !in_stall) owed_q.push_back(synth_sample(in_restart));
      fail_count  <= fails;
      outstanding <= owed_q.size();
    end
  end

endmodule

>>> bench/waveform_oscillator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_oscillator_tb: stimulus and verdict for the oscillator
// Runs a short directed set (table quadrants, square edges, ramp ends,
// unused waveform code, masked writes) and then random settings phases with
// random restarts, sender gaps and receiver stalls. Checking is done by
// wosc_sample_checker beside the block.
// ----------------------------------------------------------------------------
module waveform_oscillator_tb;
  import wosc_pkg::*;

  localparam int ITEMS = 1100;
  localparam int LIMIT = 200000;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [WAVE_W-1:0]    WAVE_SILENT = 2'd3;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_restart;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [SAMPLE_W-1:0]  out_sample;
  logic                        cfg_we;
  logic [REG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  int                          fail_count;
  int                          outstanding;
  int                          beats_sent;
  int                          stall_hold;
  bit                          jitter;

  waveform_oscillator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wosc_sample_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_restart  (in_restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls plus the odd longer burst
  always @(posedge clk) begin
    if (!rst_n || !jitter) begin
      stall_hold <= 0;
      out_stall  <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
      out_stall  <= 1'b1;
    end else begin
      if ($urandom_range(99) < 2) begin
        stall_hold <= $urandom_range(15, 5);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < 24);
      end
    end
  end

  // one input beat; returns at the edge that takes it
  task automatic send(input logic restart);
    while (jitter && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // stop sending and let every owed sample come out
  task automatic hold_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] wave_word, input logic [31:0] amp_word,
                               input logic [31:0] step_word);
    hold_idle();
    if ($urandom_range(3) == 0) set_reg(REG_UNUSED, $urandom);
    set_reg(REG_WAVEFORM, wave_word);
    set_reg(REG_AMPLITUDE, amp_word);
    set_reg(REG_PHASE_STEP, step_word);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [WAVE_W-1:0] wave;
    logic [AMP_W-1:0]  amp;
    logic [31:0]       phase_inc;
    int                run_len;
    int                phase_no;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_WAVEFORM;
    cfg_data   = '0;
    beats_sent = 0;
    jitter     = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // quarter steps land on zero, peak, zero, trough
    load_settings(WAVE_SINE, 32'd32767, 32'h4000_0000);
    send(1'b1);
    repeat (4) send(1'b0);
    // square at phase zero and exactly one half, upper bits of the words ignored
    load_settings({30'h3FFF_FFFF, WAVE_SQUARE}, 32'hFFFF_FFFF, 32'h8000_0000);
    send(1'b1);
    send(1'b0);
    send(1'b0);
    // smallest positive phase
    load_settings(WAVE_SQUARE, 32'd1, 32'd1);
    send(1'b1);
    send(1'b0);
    // ramp at both ends, phase wraps
    load_settings(WAVE_SAWTOOTH, 32'd32767, 32'hFFFF_FFFF);
    send(1'b1);
    send(1'b0);
    send(1'b0);
    // unused code is silent but the phase keeps moving
    load_settings(WAVE_SILENT, 32'd32767, 32'h1234_5678);
    send(1'b1);
    send(1'b0);
    load_settings(WAVE_SAWTOOTH, 32'd32767, 32'd0);
    send(1'b0);
    load_settings(WAVE_SINE, 32'd0, 32'h0123_4567);
    send(1'b0);
    send(1'b1);

    phase_no = 0;
    while (beats_sent < ITEMS) begin
      wave = ($urandom_range(9) == 0) ? WAVE_SILENT : WAVE_W'($urandom_range(2));
      case ($urandom_range(5))
        0:       amp = '0;
        1:       amp = 15'd32767;
        default: amp = AMP_W'($urandom);
      endcase
      case ($urandom_range(4))
        0:       phase_inc = $urandom_range(4096);
        1:       phase_inc = 32'hFFFF_FFFF - $urandom_range(4096);
        default: phase_inc = $urandom;
      endcase
      load_settings(($urandom & ~32'h3) | 32'(wave), ($urandom & ~32'h7FFF) | 32'(amp),
                    phase_inc);
      // one phase runs with neither side idling
      jitter  <= (phase_no != 3);
      run_len  = $urandom_range(120, 20);
      repeat (run_len) send($urandom_range(19) == 0);
      phase_no++;
    end

    jitter <= 1'b1;
    hold_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
